// ===== rtl/wsfu_pkg.sv =====
// Shared types and constants for the WebSocket frame unmasker.
package wsfu_pkg;

  localparam int LENGTH_WIDTH_DEFAULT = 32;

  localparam logic [7:0] FIRST_BYTE  = 8'h81;
  localparam logic [7:0] MASK_BIT    = 8'h80;
  localparam logic [6:0] LEN7_MASK   = 7'h7F;
  localparam logic [6:0] LEN7_MAX    = 7'd125;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DRAIN   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_REJECT    = 2'd2,
    ST_EARLY_END = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       data_valid;
    logic       last;
    status_t    status;
  } out_item_t;

endpackage

// ===== rtl/websocket_frame_unmasker_unit.sv =====
// Top level of the WebSocket frame unmasker.
// Takes one frame-buffer byte per clock and gives at most one result per byte, registered first in
// the input register and then in the result register. The sustained rate is one byte per
// clock while the output side is not stalling; it is set by the header/payload state registers,
// which take one byte per cycle. The input side stalls only while the result register holds
// a result that the output side is stalling.
module websocket_frame_unmasker_unit #(
  parameter int LENGTH_WIDTH = wsfu_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                raw_valid,
  output logic                raw_stall,
  input  wsfu_pkg::in_item_t  raw,
  output logic                result_valid,
  input  logic                result_stall,
  output wsfu_pkg::out_item_t result
);

  logic                item_valid;
  wsfu_pkg::in_item_t  item;
  logic                out_free;
  logic                advance;
  logic                res_valid;
  wsfu_pkg::out_item_t res;

  assign advance   = item_valid && out_free;
  assign raw_stall = item_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!raw_stall) begin
      item_valid <= raw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!raw_stall && raw_valid) begin
      item <= raw;
    end
  end

  wsfu_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfu_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && res_valid),
    .load_data    (res),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/wsfu_parser.sv =====
// Frame header parser, length/key state and payload unmasking.
module wsfu_parser #(
  parameter int LENGTH_WIDTH = wsfu_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  wsfu_pkg::in_item_t  item,
  output logic                res_valid,
  output wsfu_pkg::out_item_t res
);

  wsfu_pkg::phase_t          phase, phase_next;
  logic [3:0]                header_bytes_left, header_bytes_left_next;
  logic [LENGTH_WIDTH-1:0]   payload_length, payload_length_next;
  logic [31:0]               mask_key, mask_key_next;
  logic [LENGTH_WIDTH-1:0]   payload_remaining, payload_remaining_next;
  logic [1:0]                key_index, key_index_next;

  logic [7:0] b;
  logic [6:0] l7;
  logic       eob;
  logic       count_done;
  logic       len_zero;
  logic       fin;
  logic [7:0] key_byte;

  assign b          = item.in_byte;
  assign eob        = item.end_of_buffer;
  assign l7         = b[6:0] & wsfu_pkg::LEN7_MASK;
  assign count_done = (header_bytes_left == 4'd1);
  assign len_zero   = (payload_length == '0);
  assign fin        = (payload_remaining == LENGTH_WIDTH'(1));

  always_comb begin
    case (key_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_next             = phase;
    header_bytes_left_next = header_bytes_left;
    payload_length_next    = payload_length;
    mask_key_next          = mask_key;
    payload_remaining_next = payload_remaining;
    key_index_next         = key_index;
    if (step) begin
      unique case (phase)
        wsfu_pkg::PH_FIRST: begin
          phase_next = (b != wsfu_pkg::FIRST_BYTE) ? wsfu_pkg::PH_DRAIN
                                                   : wsfu_pkg::PH_SECOND;
        end
        wsfu_pkg::PH_SECOND: begin
          if ((b & wsfu_pkg::MASK_BIT) == 8'h00) begin
            phase_next = wsfu_pkg::PH_DRAIN;
          end else if (l7 <= wsfu_pkg::LEN7_MAX) begin
            payload_length_next    = LENGTH_WIDTH'(l7);
            header_bytes_left_next = wsfu_pkg::KEY_BYTES;
            phase_next             = wsfu_pkg::PH_KEY;
          end else begin
            payload_length_next    = '0;
            header_bytes_left_next = (l7 == wsfu_pkg::LEN_EXT16) ? wsfu_pkg::EXT16_BYTES
                                                                 : wsfu_pkg::EXT64_BYTES;
            phase_next             = wsfu_pkg::PH_EXTLEN;
          end
        end
        wsfu_pkg::PH_EXTLEN: begin
          payload_length_next    = {payload_length[LENGTH_WIDTH-9:0], b};
          header_bytes_left_next = header_bytes_left - 4'd1;
          if (count_done) begin
            header_bytes_left_next = wsfu_pkg::KEY_BYTES;
            phase_next             = wsfu_pkg::PH_KEY;
          end
        end
        wsfu_pkg::PH_KEY: begin
          mask_key_next          = {mask_key[23:0], b};
          header_bytes_left_next = header_bytes_left - 4'd1;
          if (count_done) begin
            if (len_zero) begin
              phase_next = wsfu_pkg::PH_DRAIN;
            end else begin
              payload_remaining_next = payload_length;
              key_index_next         = 2'd0;
              phase_next             = wsfu_pkg::PH_PAYLOAD;
            end
          end
        end
        wsfu_pkg::PH_PAYLOAD: begin
          payload_remaining_next = payload_remaining - LENGTH_WIDTH'(1);
          key_index_next         = key_index + 2'd1;
          if (fin) begin
            phase_next = wsfu_pkg::PH_DRAIN;
          end
        end
        default: begin
        end
      endcase
      if (eob) begin
        phase_next             = wsfu_pkg::PH_FIRST;
        header_bytes_left_next = '0;
        payload_length_next    = '0;
        mask_key_next          = '0;
        payload_remaining_next = '0;
        key_index_next         = '0;
      end
    end
  end

  // result
  always_comb begin
    logic header_open;
    header_open = 1'b0;
    res_valid   = 1'b0;
    res         = '{out_byte: 8'h00, data_valid: 1'b0, last: 1'b0,
                    status: wsfu_pkg::ST_OK};
    unique case (phase)
      wsfu_pkg::PH_FIRST: begin
        if (b != wsfu_pkg::FIRST_BYTE) begin
          res_valid  = 1'b1;
          res.last   = 1'b1;
          res.status = wsfu_pkg::ST_REJECT;
        end else begin
          header_open = 1'b1;
        end
      end
      wsfu_pkg::PH_SECOND: begin
        if ((b & wsfu_pkg::MASK_BIT) == 8'h00) begin
          res_valid  = 1'b1;
          res.last   = 1'b1;
          res.status = wsfu_pkg::ST_REJECT;
        end else begin
          header_open = 1'b1;
        end
      end
      wsfu_pkg::PH_EXTLEN: begin
        header_open = 1'b1;
      end
      wsfu_pkg::PH_KEY: begin
        if (count_done && len_zero) begin
          res_valid  = 1'b1;
          res.last   = 1'b1;
          res.status = wsfu_pkg::ST_EMPTY;
        end else begin
          header_open = 1'b1;
        end
      end
      wsfu_pkg::PH_PAYLOAD: begin
        res_valid      = 1'b1;
        res.out_byte   = b ^ key_byte;
        res.data_valid = 1'b1;
        res.last       = fin | eob;
        res.status     = (!fin && eob) ? wsfu_pkg::ST_EARLY_END : wsfu_pkg::ST_OK;
      end
      default: begin
      end
    endcase
    if (eob && header_open) begin
      res_valid  = 1'b1;
      res.last   = 1'b1;
      res.status = wsfu_pkg::ST_EARLY_END;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= wsfu_pkg::PH_FIRST;
      header_bytes_left <= '0;
      payload_length    <= '0;
      mask_key          <= '0;
      payload_remaining <= '0;
      key_index         <= '0;
    end else begin
      phase             <= phase_next;
      header_bytes_left <= header_bytes_left_next;
      payload_length    <= payload_length_next;
      mask_key          <= mask_key_next;
      payload_remaining <= payload_remaining_next;
      key_index         <= key_index_next;
    end
  end

endmodule

// ===== rtl/wsfu_out_stage.sv =====
// Result register feeding the output channel.
module wsfu_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  wsfu_pkg::out_item_t load_data,
  output logic                free,
  output logic                result_valid,
  input  logic                result_stall,
  output wsfu_pkg::out_item_t result
);

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_data;
    end
  end

endmodule

// ===== rtl/wsfu_checker.sv =====
// Port-level assertions for the WebSocket frame unmasker, bound to the top level.
module wsfu_checker (
  input logic                clk,
  input logic                rst,
  input logic                raw_valid,
  input logic                raw_stall,
  input wsfu_pkg::in_item_t  raw,
  input logic                result_valid,
  input logic                result_stall,
  input wsfu_pkg::out_item_t result
);

  a_raw_hold: assert property (@(posedge clk) disable iff (rst)
    raw_valid && raw_stall |=> raw_valid && $stable(raw))
    else $error("stalled input transfer changed");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.data_valid |-> result.out_byte == 8'h00)
    else $error("status transfer carries a nonzero byte");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != wsfu_pkg::ST_OK |-> result.last)
    else $error("non-ok status without last");

  a_data_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.data_valid |->
      result.status == wsfu_pkg::ST_OK || result.status == wsfu_pkg::ST_EARLY_END)
    else $error("payload byte with header status");

endmodule

bind websocket_frame_unmasker_unit wsfu_checker u_wsfu_checker (
  .clk          (clk),
  .rst          (rst),
  .raw_valid    (raw_valid),
  .raw_stall    (raw_stall),
  .raw          (raw),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
